// ===== src/ahv_pkg.sv =====
// Package: constants, codes and types shared by the header validator files.
`default_nettype none

package ahv_pkg;

   // Header image layout
   localparam int HEADER_BYTES = 80;
   localparam int NAME_OFFSET  = 16;
   localparam int NAME_LIMIT   = 63;
   localparam int POS_BITS     = $clog2(HEADER_BYTES);
   // Width wide enough for the offset arithmetic at this image size
   localparam int OFS_BITS     = 9;

   // Field values
   localparam logic [31:0] MAGIC_VALUE  = 32'h314C_4257;
   localparam logic [31:0] ERASED_WORD  = 32'hFFFF_FFFF;
   localparam logic [7:0]  ERASED_BYTE  = 8'hFF;
   localparam logic [7:0]  PRINT_LOW    = 8'h20;
   localparam logic [7:0]  PRINT_HIGH   = 8'h7E;
   localparam logic [6:0]  SUBST_CHAR   = 7'h5F;

   // Register reset values
   localparam logic [31:0] PAYLOAD_LIMIT_RESET = 32'd520192;
   localparam logic [7:0]  VERSION_RESET       = 8'd2;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PAYLOAD_LIMIT    = 1'b0,
      CSR_EXPECTED_VERSION = 1'b1
   } csr_index_type;

   // Result kinds
   typedef enum logic {
      KIND_NAME_CHAR = 1'b0,
      KIND_VERDICT   = 1'b1
   } kind_type;

   // Verdict classes
   typedef enum logic [1:0] {
      VERDICT_EMPTY      = 2'd0,
      VERDICT_INCOMPLETE = 2'd1,
      VERDICT_INVALID    = 2'd2,
      VERDICT_VALID      = 2'd3
   } verdict_type;

endpackage

`default_nettype wire

// ===== src/ahv_stream_if.sv =====
// Interfaces: header byte input, result output and configuration write channels.
`default_nettype none

interface ahv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic       first_of_header;

   modport source (output valid, header_byte, first_of_header, input ready);
   modport sink   (input valid, header_byte, first_of_header, output ready);
endinterface

interface ahv_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [6:0]  name_char;
   logic [1:0]  verdict;
   logic [31:0] payload_length;
   logic [31:0] payload_crc;
   logic [5:0]  name_length;

   modport source (output valid, result_kind, name_char, verdict, payload_length,
                   payload_crc, name_length, input ready);
   modport sink   (input valid, result_kind, name_char, verdict, payload_length,
                   payload_crc, name_length, output ready);
endinterface

interface ahv_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ahv_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [31:0]                         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/asset_header_validator_unit.sv =====
// Top level: flash header image validator, one header byte per item.
//
// Usage:
//  - req_port carries one header byte per item; first_of_header restarts
//    parsing at offset zero. After the last byte of the image the next byte
//    starts a new header even without the flag.
//  - rsp_port gives at most one item per input item: a sanitized name
//    character while the header still looks good, and the verdict (with
//    length, CRC and name length, zero unless valid) on the last byte.
//  - csr_port writes payload_limit (index 0) and expected_version (index 1); it
//    is always ready; the user must write it only while idle (not enforced).
// Timing: an accepted byte sits in the input stage until the output register is
//  free; the edge that then loads its result into the output register makes it
//  valid. One byte per cycle is sustained while the receiver takes results; the
//  single parse step between the two registers sets that rate.
// Reset clears the parse state, both stages and the registers to their
//  defaults. When the receiver stalls the result holds in the output
//  register, the input stage holds one more byte, and then req ready drops.
`default_nettype none

module asset_header_validator_unit (
   input  wire         clock,
   input  wire         reset,
   ahv_req_if.sink     req_port,
   ahv_rsp_if.source   rsp_port,
   ahv_csr_if.sink     csr_port
);

   localparam int PB = ahv_pkg::POS_BITS;
   localparam int OB = ahv_pkg::OFS_BITS;

   // Configuration registers
   logic [31:0] limit_ff, limit_in;
   logic [7:0]  version_ff, version_in;

   // Input stage
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff, s1_byte_in;
   logic        s1_first_ff, s1_first_in;

   // Parse state
   logic [PB-1:0] pos_ff, pos_in;
   logic          erased_ff, erased_in;
   logic [31:0]   magic_ff, magic_in;
   logic          rejected_ff, rejected_in;
   logic [5:0]    name_size_ff, name_size_in;
   logic [31:0]   length_ff, length_in;
   logic [31:0]   crc_ff, crc_in;

   // Output register
   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic [6:0]  out_char_ff, out_char_in;
   logic [1:0]  out_verdict_ff, out_verdict_in;
   logic [31:0] out_length_ff, out_length_in;
   logic [31:0] out_crc_ff, out_crc_in;
   logic [5:0]  out_name_size_ff, out_name_size_in;

   // Handshake and parse step signals
   logic                 out_free;
   logic                 s1_adv;
   logic [PB-1:0]        pos;
   logic                 base_erased;
   logic [31:0]          base_magic;
   logic                 base_rejected;
   logic [5:0]           base_name_size;
   logic [31:0]          base_length;
   logic [31:0]          base_crc;
   logic [7:0]           b;
   logic [4:0]           lane_shift;
   logic                 at_last;
   logic                 name_hit;
   logic [OB-1:0]        name_ofs;
   ahv_pkg::verdict_type verdict_now;

   // Handshake: output register frees when empty or taken
   assign out_free       = !out_valid_ff || rsp_port.ready;
   assign s1_adv         = s1_valid_ff && out_free;
   assign req_port.ready = !s1_valid_ff || out_free;
   assign csr_port.ready = 1'b1;

   // Configuration writes
   always_comb begin
      limit_in   = limit_ff;
      version_in = version_ff;
      if (csr_port.valid) begin
         case (ahv_pkg::csr_index_type'(csr_port.index))
            ahv_pkg::CSR_PAYLOAD_LIMIT:    limit_in   = csr_port.data;
            ahv_pkg::CSR_EXPECTED_VERSION: version_in = csr_port.data[7:0];
            default:                       limit_in   = limit_ff;
         endcase
      end
   end

   // Input stage load
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_first_in = s1_first_ff;
      if (req_port.valid && req_port.ready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_port.header_byte;
         s1_first_in = req_port.first_of_header;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // Parse step: restart flag selects a cleared state as the base
   always_comb begin
      b              = s1_byte_ff;
      pos            = s1_first_ff ? '0 : pos_ff;
      base_erased    = s1_first_ff ? 1'b1 : erased_ff;
      base_magic     = s1_first_ff ? '0 : magic_ff;
      base_rejected  = s1_first_ff ? 1'b0 : rejected_ff;
      base_name_size = s1_first_ff ? '0 : name_size_ff;
      base_length    = s1_first_ff ? '0 : length_ff;
      base_crc       = s1_first_ff ? '0 : crc_ff;
      lane_shift     = {pos[1:0], 3'b000};

      erased_in    = base_erased && (b == ahv_pkg::ERASED_BYTE);
      magic_in     = base_magic;
      rejected_in  = base_rejected;
      name_size_in = base_name_size;
      length_in    = base_length;
      crc_in       = base_crc;

      // Field capture and checks by offset
      if (pos < PB'(4)) begin
         magic_in = base_magic | (32'(b) << lane_shift);
      end else if (pos == PB'(4)) begin
         if (b != version_ff) rejected_in = 1'b1;
      end else if (pos == PB'(5)) begin
         if (b > 8'(ahv_pkg::NAME_LIMIT) ||
             (OB'(b) + OB'(ahv_pkg::NAME_OFFSET)) >= OB'(ahv_pkg::HEADER_BYTES))
            rejected_in = 1'b1;
         name_size_in = b[5:0];
      end else if (pos < PB'(8)) begin
         if (b != 8'd0) rejected_in = 1'b1;
      end else if (pos < PB'(12)) begin
         length_in = base_length | (32'(b) << lane_shift);
         if (pos == PB'(11) && (length_in == 32'd0 || length_in > limit_ff))
            rejected_in = 1'b1;
      end else if (pos < PB'(16)) begin
         crc_in = base_crc | (32'(b) << lane_shift);
      end

      // Verdict class on the last byte
      at_last = (pos == PB'(ahv_pkg::HEADER_BYTES - 1));
      if (erased_in)
         verdict_now = ahv_pkg::VERDICT_EMPTY;
      else if (magic_in == ahv_pkg::ERASED_WORD)
         verdict_now = ahv_pkg::VERDICT_INCOMPLETE;
      else if (magic_in != ahv_pkg::MAGIC_VALUE || rejected_in)
         verdict_now = ahv_pkg::VERDICT_INVALID;
      else
         verdict_now = ahv_pkg::VERDICT_VALID;

      // Name byte in use while the header still looks good
      name_ofs = OB'(pos) - OB'(ahv_pkg::NAME_OFFSET);
      name_hit = (pos >= PB'(ahv_pkg::NAME_OFFSET)) && (name_ofs < OB'(name_size_in)) &&
                 (magic_in == ahv_pkg::MAGIC_VALUE) && !rejected_in;

      pos_in = pos + PB'(1);
      // The verdict clears the state for the next header
      if (at_last) begin
         pos_in       = '0;
         erased_in    = 1'b1;
         magic_in     = '0;
         rejected_in  = 1'b0;
         name_size_in = '0;
         length_in    = '0;
         crc_in       = '0;
      end
   end

   // Output register load
   always_comb begin
      out_valid_in     = out_valid_ff && !rsp_port.ready;
      out_kind_in      = out_kind_ff;
      out_char_in      = out_char_ff;
      out_verdict_in   = out_verdict_ff;
      out_length_in    = out_length_ff;
      out_crc_in       = out_crc_ff;
      out_name_size_in = out_name_size_ff;
      if (s1_adv && at_last) begin
         out_valid_in     = 1'b1;
         out_kind_in      = ahv_pkg::KIND_VERDICT;
         out_char_in      = '0;
         out_verdict_in   = verdict_now;
         out_length_in    = (verdict_now == ahv_pkg::VERDICT_VALID) ? length_ff : '0;
         out_crc_in       = (verdict_now == ahv_pkg::VERDICT_VALID) ? crc_ff : '0;
         out_name_size_in = (verdict_now == ahv_pkg::VERDICT_VALID) ? name_size_ff : '0;
         if (s1_first_ff) begin
            out_length_in    = '0;
            out_crc_in       = '0;
            out_name_size_in = '0;
         end
      end else if (s1_adv && name_hit) begin
         out_valid_in     = 1'b1;
         out_kind_in      = ahv_pkg::KIND_NAME_CHAR;
         out_char_in      = (b >= ahv_pkg::PRINT_LOW && b <= ahv_pkg::PRINT_HIGH) ?
                            b[6:0] : ahv_pkg::SUBST_CHAR;
         out_verdict_in   = ahv_pkg::VERDICT_EMPTY;
         out_length_in    = '0;
         out_crc_in       = '0;
         out_name_size_in = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= ahv_pkg::PAYLOAD_LIMIT_RESET;
         version_ff   <= ahv_pkg::VERSION_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         erased_ff    <= 1'b1;
         magic_ff     <= '0;
         rejected_ff  <= 1'b0;
         name_size_ff <= '0;
         length_ff    <= '0;
         crc_ff       <= '0;
      end else begin
         limit_ff     <= limit_in;
         version_ff   <= version_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_adv) begin
            pos_ff       <= pos_in;
            erased_ff    <= erased_in;
            magic_ff     <= magic_in;
            rejected_ff  <= rejected_in;
            name_size_ff <= name_size_in;
            length_ff    <= length_in;
            crc_ff       <= crc_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_byte_ff       <= s1_byte_in;
      s1_first_ff      <= s1_first_in;
      out_kind_ff      <= out_kind_in;
      out_char_ff      <= out_char_in;
      out_verdict_ff   <= out_verdict_in;
      out_length_ff    <= out_length_in;
      out_crc_ff       <= out_crc_in;
      out_name_size_ff <= out_name_size_in;
   end

   assign rsp_port.valid          = out_valid_ff;
   assign rsp_port.result_kind    = out_kind_ff;
   assign rsp_port.name_char      = out_char_ff;
   assign rsp_port.verdict        = out_verdict_ff;
   assign rsp_port.payload_length = out_length_ff;
   assign rsp_port.payload_crc    = out_crc_ff;
   assign rsp_port.name_length    = out_name_size_ff;

`ifndef SYNTH
   // Only a valid verdict carries length, CRC and name length
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff && out_verdict_ff != ahv_pkg::VERDICT_VALID |->
         out_length_ff == 32'd0 && out_crc_ff == 32'd0 && out_name_size_ff == 6'd0)
      else $error("non-valid verdict carries header fields");

   // Name characters are printable ASCII
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_kind_ff |->
         out_char_ff >= ahv_pkg::PRINT_LOW[6:0] && out_char_ff <= ahv_pkg::PRINT_HIGH[6:0])
      else $error("name character not printable");

   // Byte position stays inside the image
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PB'(ahv_pkg::HEADER_BYTES - 1))
      else $error("byte position beyond image");

   // A verdict restarts parsing at offset zero
   assert property (@(posedge clock) disable iff (reset)
      s1_adv && at_last |=> pos_ff == '0 && erased_ff)
      else $error("parse state not cleared after verdict");
`endif

endmodule

`default_nettype wire
